FILE: rtl/core/median_filter_assert.svh
// ----------------------------------------------------------------------------
// median filter assertion macros
// shared concurrent assertion forms, reported through $error
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_ASSERT_SVH
`define MEDIAN_FILTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define MF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg
// shared types and constants of the median filter
// ----------------------------------------------------------------------------
`default_nettype none
package mf_pkg;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 4;
    localparam int ROW_W     = 12;
    localparam int HEIGHT_MAX = 4096;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    // control from the sequencer to every lane
    typedef struct packed {
        logic       start;
        logic       load;
        logic       step;
        logic [2:0] bit_idx;
    } t_lane_ctl;
endpackage
`default_nettype wire

FILE: rtl/core/mf_lane.sv
// ----------------------------------------------------------------------------
// mf_lane
// one channel lane: holds the window taps and finds the median bit by bit
// ----------------------------------------------------------------------------
`default_nettype none
module mf_lane
    import mf_pkg::*;
#(
    parameter int MAXT = 49
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_lane_ctl                   i_ctl,
    input  wire logic [$clog2(MAXT)-1:0]     i_idx,
    input  wire logic [CHAN_W-1:0]           i_val,
    input  wire logic [$clog2(MAXT+1)-1:0]   i_ntaps,
    output logic      [CHAN_W-1:0]           o_med
);
    localparam int NW = $clog2(MAXT + 1);

    logic [CHAN_W-1:0] r_tap [MAXT];
    logic [MAXT-1:0]   r_alive;
    logic [NW-1:0]     r_rank;
    logic [CHAN_W-1:0] r_med;
    logic [MAXT-1:0]   bitv;
    logic [NW-1:0]     cnt;
    logic [MAXT-1:0]   init_mask;

    always_comb begin
        for (int i = 0; i < MAXT; i++) begin
            bitv[i]      = r_tap[i][i_ctl.bit_idx];
            init_mask[i] = (NW'(i) < i_ntaps);
        end
        cnt = NW'($countones(r_alive & ~bitv));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tap[i_idx] <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_rank  <= '0;
            r_med   <= '0;
        end else if (i_ctl.start) begin
            r_alive <= init_mask;
            r_rank  <= i_ntaps >> 1;
            r_med   <= '0;
        end else if (i_ctl.step) begin
            // rank below the zero count: the median has a zero here
            if (r_rank < cnt) begin
                r_alive <= r_alive & ~bitv;
            end else begin
                r_alive <= r_alive & bitv;
                r_rank  <= r_rank - cnt;
                r_med[i_ctl.bit_idx] <= 1'b1;
            end
        end
    end

    assign o_med = r_med;
endmodule
`default_nettype wire

FILE: rtl/core/mf_merge.sv
// ----------------------------------------------------------------------------
// mf_merge
// gathers the lane medians, blanks unused channels, holds the result item
// ----------------------------------------------------------------------------
`default_nettype none
module mf_merge
    import mf_pkg::*;
#(
    parameter int LANES = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CHAN_W-1:0] i_lane_med [LANES],
    input  wire logic [2:0]        i_chan_cnt,
    input  wire logic              i_frame_end,
    input  wire logic              i_load,
    output logic                   o_can_load,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CHAN_W-1:0]      o_med [NUM_CHAN],
    output logic                   o_frame_end
);
    logic              r_valid;
    logic [CHAN_W-1:0] r_med [NUM_CHAN];
    logic              r_fe;
    logic [CHAN_W-1:0] n_med [NUM_CHAN];

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            n_med[c] = '0;
            if (c < LANES && 3'(c) < i_chan_cnt) begin
                n_med[c] = i_lane_med[c % LANES];
            end
        end
    end

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_med <= n_med;
            r_fe  <= i_frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_med       = r_med;
    assign o_frame_end = r_fe;
endmodule
`default_nettype wire

FILE: rtl/core/median_filter.sv
// item flow: the sequencer takes one item at a time; an item that yields a result
//   holds off the next one until its result enters the merge stage, a span set by
//   the single line store read port (one window tap per cycle) and the 8-step
//   bitwise median search; items that yield no result leave the input ready
// reset: synchronous active-low; counters and control clear, the line store
//   keeps its contents and needs no clearing pass
// ----------------------------------------------------------------------------
// median_filter
// streaming square-window median filter, one median per colour channel
// ----------------------------------------------------------------------------
`default_nettype none
module median_filter
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3,
    parameter int LANES      = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [12:0]       i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_operation,
    input  wire logic [CHAN_W-1:0] i_chan0,
    input  wire logic [CHAN_W-1:0] i_chan1,
    input  wire logic [CHAN_W-1:0] i_chan2,
    input  wire logic [CHAN_W-1:0] i_chan3,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CHAN_W-1:0]      o_med0,
    output logic [CHAN_W-1:0]      o_med1,
    output logic [CHAN_W-1:0]      o_med2,
    output logic [CHAN_W-1:0]      o_med3,
    output logic                   o_frame_end
);
    // derived sizes
    localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int MAXT  = STORE_ROWS * STORE_ROWS;
    localparam int TW    = $clog2(MAXT);
    localparam int NW    = $clog2(MAXT + 1);
    localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(STORE_ROWS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = XW + 2;                 // signed window column
    localparam int YW    = ROW_W + 2;              // signed window row
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int LAGW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int DW    = LANES * CHAN_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GATHER = 3'd1;
    localparam logic [2:0] ST_SETTLE = 3'd2;
    localparam logic [2:0] ST_SORT   = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    // configuration registers
    logic [10:0] r_cfg_w;
    logic [12:0] r_cfg_h;
    logic [2:0]  r_cfg_c;
    logic [1:0]  r_cfg_r;

    // effective values after clamping
    logic [XW:0]      w_eff;
    logic [XW-1:0]    wm1;
    logic [12:0]      h_eff;
    logic [ROW_W-1:0] hm1;
    logic [2:0]       c_eff;
    logic [RW-1:0]    r_eff;
    logic [LAGW-1:0]  lag;
    logic [NW-1:0]    ntaps;
    logic [3:0]       wdim;

    always_comb begin
        logic [12:0] wt;
        wt = {2'b00, r_cfg_w};
        if (wt == 13'd0) begin
            wt = 13'd1;
        end else if (wt > 13'(MAX_WIDTH)) begin
            wt = 13'(MAX_WIDTH);
        end
        w_eff = (XW+1)'(wt);
        wm1   = XW'(w_eff - 1'b1);
        if (r_cfg_h == 13'd0) begin
            h_eff = 13'd1;
        end else if (r_cfg_h > 13'(HEIGHT_MAX)) begin
            h_eff = 13'(HEIGHT_MAX);
        end else begin
            h_eff = r_cfg_h;
        end
        hm1 = ROW_W'(h_eff - 13'd1);
        if (r_cfg_c == 3'd0) begin
            c_eff = 3'd1;
        end else if (r_cfg_c > 3'(LANES)) begin
            c_eff = 3'(LANES);
        end else begin
            c_eff = r_cfg_c;
        end
        if ({1'b0, r_cfg_r} > 3'(MAX_RADIUS)) begin
            r_eff = RW'(MAX_RADIUS);
        end else begin
            r_eff = RW'(r_cfg_r);
        end
        // delay from first pixel to first result: r rows plus r pixels
        lag   = LAGW'(r_eff) * LAGW'(w_eff) + LAGW'(r_eff);
        wdim  = {3'(r_eff), 1'b1};
        ntaps = NW'(wdim) * NW'(wdim);
    end

    // stream counters
    logic [XW-1:0]    r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [SW-1:0]    r_in_slot, r_out_slot;
    logic [LAGW-1:0]  r_item_cnt;
    logic             r_done;

    // window sequencer
    logic [2:0]       r_state;
    logic signed [YW-1:0] r_rr;
    logic signed [CW-1:0] r_cc, r_cend, r_cstart;
    logic [SW-1:0]    r_slot, r_prev_eff;
    logic [TW-1:0]    r_tap;
    logic             r_rd_vld;
    logic [TW-1:0]    r_rd_idx;
    logic [2:0]       r_bit;
    logic             r_fe;

    // line store
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] wr_word;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_en;

    logic [CHAN_W-1:0] in_chan [NUM_CHAN];
    assign in_chan[0] = i_chan0;
    assign in_chan[1] = i_chan1;
    assign in_chan[2] = i_chan2;
    assign in_chan[3] = i_chan3;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            wr_word[l*CHAN_W +: CHAN_W] = in_chan[l];
        end
    end

    // item handshake: the sequencer takes one item at a time
    logic acc, is_pixel, counts, emits, in_row_last, in_frame_last, out_last;
    assign o_ready  = (r_state == ST_IDLE);
    assign acc      = i_valid && o_ready;
    assign is_pixel = !r_done && (i_operation == OP_PIXEL);
    // early flush is dropped, surplus pixel behaves as a flush
    assign counts   = r_done || (i_operation == OP_PIXEL);
    assign emits    = acc && counts && (r_item_cnt >= lag);
    assign wr_en    = acc && is_pixel;
    assign wr_addr  = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    assign in_row_last   = ({1'b0, r_in_col} + 1'b1) >= w_eff;
    assign in_frame_last = ({1'b0, r_in_row} + 13'd1) >= h_eff;
    assign out_last      = (r_out_row >= hm1) && (r_out_col >= wm1);

    // window address: clamp row and column to the image
    logic [SW-1:0] eff_slot;
    logic [XW-1:0] nx;
    logic          row_end;
    always_comb begin
        if (r_rr[YW-1]) begin
            eff_slot = '0;
        end else if (r_rr[YW-2:0] > (YW-1)'(hm1)) begin
            eff_slot = r_prev_eff;      // beyond the last row: repeat it
        end else begin
            eff_slot = r_slot;
        end
        if (r_cc[CW-1]) begin
            nx = '0;
        end else if (r_cc[CW-2:0] > (CW-1)'(wm1)) begin
            nx = wm1;
        end else begin
            nx = XW'(r_cc[CW-2:0]);
        end
        rd_addr = AW'(eff_slot) * AW'(MAX_WIDTH) + AW'(nx);
        row_end = (r_cc == r_cend);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
    end

    // merge stage handshake
    logic merge_can_load, merge_load;
    assign merge_load = (r_state == ST_FIN) && merge_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 11'd1024;
            r_cfg_h <= 13'd1;
            r_cfg_c <= 3'd3;
            r_cfg_r <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:    r_cfg_w <= i_cfg_data[10:0];
                REG_HEIGHT:   r_cfg_h <= i_cfg_data;
                REG_CHANNELS: r_cfg_c <= i_cfg_data[2:0];
                REG_RADIUS:   r_cfg_r <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stream position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_item_cnt <= '0;
            r_done     <= 1'b0;
        end else if (acc && counts) begin
            if (emits && out_last) begin
                // final result of the frame: everything starts over
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
                r_item_cnt <= '0;
                r_done     <= 1'b0;
            end else begin
                if (is_pixel) begin
                    if (in_row_last) begin
                        r_in_col <= '0;
                        if (in_frame_last) begin
                            r_in_row  <= '0;
                            r_in_slot <= '0;
                            r_done    <= 1'b1;
                        end else begin
                            r_in_row  <= r_in_row + 1'b1;
                            r_in_slot <= (r_in_slot == SW'(STORE_ROWS - 1)) ? '0
                                                                             : r_in_slot + 1'b1;
                        end
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                if (!emits) begin
                    r_item_cnt <= r_item_cnt + 1'b1;
                end else if (({1'b0, r_out_col} + 1'b1) >= w_eff) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + 1'b1;
                    r_out_slot <= (r_out_slot == SW'(STORE_ROWS - 1)) ? '0
                                                                       : r_out_slot + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // window start: top-left corner, slot of the top row wrapped into the store
    logic signed [CW-1:0] cstart, cend;
    logic [SW-1:0]        slot_start;
    always_comb begin
        cstart = CW'({2'b00, r_out_col}) - CW'(r_eff);
        cend   = CW'({2'b00, r_out_col}) + CW'(r_eff);
        if (r_out_slot >= SW'(r_eff)) begin
            slot_start = r_out_slot - SW'(r_eff);
        end else begin
            slot_start = SW'(r_out_slot + SW'(STORE_ROWS) - SW'(r_eff));
        end
    end

    // sequencer: gather taps, settle, 8 search steps, hand over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (emits) begin
                        r_state <= ST_GATHER;
                    end
                end
                ST_GATHER: begin
                    r_rd_vld <= 1'b1;
                    if (r_tap == TW'(ntaps - 1'b1)) begin
                        r_state <= ST_SETTLE;
                    end
                end
                ST_SETTLE: begin
                    r_state <= ST_SORT;
                end
                ST_SORT: begin
                    if (r_bit == 3'd0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (merge_can_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // window walk registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_tap;
        if (r_state == ST_IDLE && emits) begin
            r_rr       <= YW'({2'b00, r_out_row}) - YW'(r_eff);
            r_cc       <= cstart;
            r_cstart   <= cstart;
            r_cend     <= cend;
            r_slot     <= slot_start;
            r_prev_eff <= '0;
            r_tap      <= '0;
            r_fe       <= out_last;
            r_bit      <= 3'd7;
        end else if (r_state == ST_GATHER) begin
            r_tap <= r_tap + 1'b1;
            if (row_end) begin
                r_cc       <= r_cstart;
                r_rr       <= r_rr + 1'b1;
                r_slot     <= (r_slot == SW'(STORE_ROWS - 1)) ? '0 : r_slot + 1'b1;
                r_prev_eff <= eff_slot;
            end else begin
                r_cc <= r_cc + 1'b1;
            end
        end else if (r_state == ST_SORT) begin
            r_bit <= r_bit - 1'b1;
        end
    end

    // lanes, one per channel
    t_lane_ctl lane_ctl;
    assign lane_ctl.start   = (r_state == ST_IDLE) && emits;
    assign lane_ctl.load    = r_rd_vld;
    assign lane_ctl.step    = (r_state == ST_SORT);
    assign lane_ctl.bit_idx = r_bit;

    logic [CHAN_W-1:0] lane_med [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        mf_lane #(
            .MAXT (MAXT)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_idx   (r_rd_idx),
            .i_val   (r_rdata[l*CHAN_W +: CHAN_W]),
            .i_ntaps (ntaps),
            .o_med   (lane_med[l])
        );
    end

    // merge stage and result register
    logic [CHAN_W-1:0] out_med [NUM_CHAN];

    mf_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lane_med  (lane_med),
        .i_chan_cnt  (c_eff),
        .i_frame_end (r_fe),
        .i_load      (merge_load),
        .o_can_load  (merge_can_load),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_med       (out_med),
        .o_frame_end (o_frame_end)
    );

    assign o_med0 = out_med[0];
    assign o_med1 = out_med[1];
    assign o_med2 = out_med[2];
    assign o_med3 = out_med[3];

    // the window walk visits every tap once: read index stays below the tap count

    `include "median_filter_assert.svh"

    `MF_ASSERT_NOW(a_tap_range, i_clk, i_rst_n, r_rd_vld, {1'b0, r_rd_idx} < NW'(ntaps))
    `MF_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, merge_load, o_valid)
    `MF_ASSERT_NEXT(a_sort_ends, i_clk, i_rst_n, (r_state == ST_SORT) && (r_bit == 3'd0), r_state == ST_FIN)
    `MF_ASSERT_NOW(a_no_result_busy, i_clk, i_rst_n, r_state != ST_FIN, !merge_load)
endmodule
`default_nettype wire

FILE: bench/median_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median_filter_tb
// self-checking bench for the streaming square-window median filter: a
// directed table with hand-read results, then random frames of many shapes
// checked against a behavioural model of the line store and window median
// ----------------------------------------------------------------------------
module median_filter_tb;
    import mf_pkg::*;

    localparam int MAXW      = 1024;
    localparam int MAXR      = 3;
    localparam int ROWS      = 2 * MAXR + 1;
    localparam int SETTLE    = 80;
    localparam int LIMIT     = 1000000;
    localparam int RAND_ITEMS = 550;

    // one output pixel
    typedef struct packed {
        logic [7:0] med0;
        logic [7:0] med1;
        logic [7:0] med2;
        logic [7:0] med3;
        logic       frame_end;
    } pix_t;

    // one row of the directed table
    typedef struct {
        int         cfg_set;    // which register set the row runs under
        logic       op;
        logic [31:0] word;      // chan3..chan0
        bit         typed;      // result read off by hand
        bit         yields;
        pix_t       res;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [12:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_operation;
    logic [7:0]  i_chan0, i_chan1, i_chan2, i_chan3;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_med0, o_med1, o_med2, o_med3;
    logic        o_frame_end;

    median_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_operation(i_operation),
        .i_chan0(i_chan0), .i_chan1(i_chan1), .i_chan2(i_chan2), .i_chan3(i_chan3),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_med0(o_med0), .o_med1(o_med1), .o_med2(o_med2), .o_med3(o_med3),
        .o_frame_end(o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    // model of the filter: registers at the DUT register widths, store and counters
    logic [31:0] line_copy [0:ROWS*MAXW-1];
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  chans_reg;
    logic [1:0]  radius_reg;
    int unsigned in_col, in_row, out_col, out_row, items_seen;
    bit          frame_stored;

    pix_t        pending_pix[$];      // output pixels still to come
    int          errors = 0;
    int          pixels_seen = 0;
    int          frames_done = 0;
    int          phases = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          calm = 0;            // no idling on either side

    function automatic int unsigned eff_w();
        if (width_reg == 0) return 1;
        return (width_reg > MAXW) ? MAXW : width_reg;
    endfunction

    function automatic int unsigned eff_h();
        if (height_reg == 0) return 1;
        return (height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg;
    endfunction

    function automatic int unsigned eff_c();
        if (chans_reg == 0) return 1;
        return (chans_reg > NUM_CHAN) ? NUM_CHAN : chans_reg;
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        items_seen = 0; frame_stored = 0;
    endfunction

    function automatic void model_config(logic [1:0] idx, logic [12:0] data);
        case (idx)
            REG_WIDTH:    width_reg  = data[10:0];
            REG_HEIGHT:   height_reg = data;
            REG_CHANNELS: chans_reg  = data[2:0];
            REG_RADIUS:   radius_reg = data[1:0];
        endcase
        restart_frame();
    endfunction

    // rank n/2 of the clamped (2r+1)^2 window of one lane
    function automatic logic [7:0] lane_median(int lane, int w, int h, int r);
        logic [7:0] vals [0:48];
        logic [7:0] v;
        int n, j, ny, nx;
        n = 0;
        for (int dy = -r; dy <= r; dy++) begin
            ny = int'(out_row) + dy;
            if (ny < 0) ny = 0;
            if (ny > h - 1) ny = h - 1;
            for (int dx = -r; dx <= r; dx++) begin
                nx = int'(out_col) + dx;
                if (nx < 0) nx = 0;
                if (nx > w - 1) nx = w - 1;
                v = line_copy[(ny % ROWS) * MAXW + nx][8*lane +: 8];
                j = n;
                while (j > 0 && vals[j-1] > v) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = v;
                n++;
            end
        end
        return vals[n/2];
    endfunction

    // advance the model by one accepted item; returns 1 when a pixel comes out
    function automatic bit filter_step(logic op, logic [31:0] word, output pix_t res);
        int unsigned w, h, r, c, lag;
        logic [7:0] m [4];
        w = eff_w(); h = eff_h(); r = radius_reg; c = eff_c();
        lag = r * w + r;
        res = '0;
        if (!frame_stored) begin
            if (op == OP_FLUSH) return 0;
            if (in_col >= w) in_col = w - 1;
            line_copy[(in_row % ROWS) * MAXW + in_col] = word;
            if (++in_col >= w) begin
                in_col = 0;
                if (++in_row >= h) begin
                    in_row = 0;
                    frame_stored = 1;
                end
            end
        end
        if (items_seen < lag) begin
            items_seen++;
            return 0;
        end
        items_seen++;
        for (int l = 0; l < 4; l++) m[l] = (l < c) ? lane_median(l, w, h, r) : 8'd0;
        res.med0 = m[0]; res.med1 = m[1]; res.med2 = m[2]; res.med3 = m[3];
        if (out_row >= h - 1 && out_col >= w - 1) begin
            res.frame_end = 1'b1;
            restart_frame();
        end else begin
            if (++out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    // sender: random gap, then hold the item until it is taken
    task automatic send_item(logic op, logic [31:0] word, bit typed = 0,
                             bit yields = 0, pix_t hand = '0);
        int gap;
        pix_t res;
        bit got;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        {i_chan3, i_chan2, i_chan1, i_chan0} <= word;
        do @(posedge i_clk); while (!o_ready);
        got = filter_step(op, word, res);
        if (typed) begin
            got = yields;
            res = hand;
        end
        if (got) pending_pix = {pending_pix, res};
        items_sent++;
    endtask

    // let every result drain, then wait out a possible result still in flight
    task automatic drain_all();
        i_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [12:0] w, logic [12:0] h, logic [12:0] c,
                              logic [12:0] r);
        logic [12:0] vals [4];
        vals = '{w, h, c, r};
        drain_all();
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            model_config(2'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
        phases++;
    endtask

    // one frame: mostly well formed, with early flushes, surplus pixels
    // in the drain, and now and then a frame cut short
    task automatic random_frame(int npix, int lag, bit cut);
        int stop;
        stop = cut ? $urandom_range(0, npix) : npix;
        for (int p = 0; p < stop; p++) begin
            if ($urandom_range(0, 19) == 0) send_item(OP_FLUSH, $urandom);
            if ($urandom_range(0, 59) == 0) drain_all();
            send_item(OP_PIXEL, $urandom);
        end
        if (cut) return;
        for (int d = 0; d < lag; d++)
            send_item($urandom_range(0, 9) < 3 ? OP_PIXEL : OP_FLUSH, $urandom);
        if ($urandom_range(0, 4) == 0) send_item(OP_FLUSH, $urandom);
    endtask

    // receiver: random stall before each result, some stretches without
    always begin
        int stall;
        stall = calm ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
            i_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        i_ready <= 1'b1;
        do @(posedge i_clk); while (!(o_valid && i_ready));
    end

    // checker of every output pixel against the oldest expected one
    always @(posedge i_clk) begin
        pix_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_med0, o_med1, o_med2, o_med3, o_frame_end};
            pixels_seen++;
            if (got.frame_end) frames_done++;
            if (pending_pix.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output pixel %h", got);
            end else begin
                want = pending_pix.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected m0=%h m1=%h m2=%h m3=%h end=%b,",
                                  " got m0=%h m1=%h m2=%h m3=%h end=%b"},
                                 want.med0, want.med1, want.med2, want.med3, want.frame_end,
                                 got.med0, got.med1, got.med2, got.med3, got.frame_end);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    row_t table_rows[$];

    function automatic void add_row(int set, logic op, logic [31:0] word,
                                    bit typed = 0, bit yields = 0, pix_t res = '0);
        row_t t;
        t.cfg_set = set; t.op = op; t.word = word;
        t.typed = typed; t.yields = yields; t.res = res;
        table_rows = {table_rows, t};
    endfunction

    initial begin
        int set_now, w, h, r, start;
        logic [12:0] wv, hv, cv;
        logic [12:0] dir_cfg [3][4];

        for (int i = 0; i < ROWS * MAXW; i++) line_copy[i] = '0;
        width_reg = 11'd1024; height_reg = 13'd1; chans_reg = 3'd3; radius_reg = 2'd1;
        restart_frame();

        i_rst_n <= 1'b0; i_cfg_we <= 1'b0; i_cfg_idx <= '0; i_cfg_data <= '0;
        i_valid <= 1'b0; i_operation <= OP_PIXEL;
        i_chan0 <= '0; i_chan1 <= '0; i_chan2 <= '0; i_chan3 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed register sets: r=0 pass-through, small 3x2 frame, single
        // pixel under the widest window
        dir_cfg = '{'{13'd2, 13'd2, 13'd4, 13'd0},
                    '{13'd3, 13'd2, 13'd2, 13'd1},
                    '{13'd1, 13'd1, 13'd1, 13'd3}};
        // r=0: early flush is ignored, each pixel is its own median
        add_row(0, OP_FLUSH, 32'h1234_5678, 1, 0);
        add_row(0, OP_PIXEL, 32'h0000_0000, 1, 1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
        add_row(0, OP_PIXEL, 32'hffff_ffff, 1, 1, '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0});
        add_row(0, OP_PIXEL, 32'hfe7f_8001, 1, 1, '{8'h01, 8'h80, 8'h7f, 8'hfe, 1'b0});
        add_row(0, OP_PIXEL, 32'hc33c_5aa5, 1, 1, '{8'ha5, 8'h5a, 8'h3c, 8'hc3, 1'b1});
        // 3x2, r=1, two channels: early flush, surplus pixel in the drain
        add_row(1, OP_FLUSH, 32'hdead_beef);
        add_row(1, OP_PIXEL, 32'h0000_00ff);
        add_row(1, OP_PIXEL, 32'hffff_ff00);
        add_row(1, OP_PIXEL, 32'h1111_8040);
        add_row(1, OP_PIXEL, 32'h2222_20c0);
        add_row(1, OP_PIXEL, 32'h3333_7f7f);
        add_row(1, OP_PIXEL, 32'h4444_0101);
        add_row(1, OP_PIXEL, 32'hffff_ffff);
        add_row(1, OP_FLUSH, 32'h0);
        add_row(1, OP_FLUSH, 32'h0);
        add_row(1, OP_FLUSH, 32'h0);
        // one pixel, radius 3: every tap clamps onto it, unused lanes give zero
        add_row(2, OP_PIXEL, 32'h7766_559a);
        for (int i = 0; i < 5; i++) add_row(2, OP_FLUSH, 32'h0, 1, 0);
        add_row(2, OP_FLUSH, 32'h0, 1, 1, '{8'h9a, 8'h00, 8'h00, 8'h00, 1'b1});

        set_now = -1;
        foreach (table_rows[i]) begin
            if (table_rows[i].cfg_set != set_now) begin
                set_now = table_rows[i].cfg_set;
                write_regs(dir_cfg[set_now][0], dir_cfg[set_now][1],
                           dir_cfg[set_now][2], dir_cfg[set_now][3]);
            end
            send_item(table_rows[i].op, table_rows[i].word, table_rows[i].typed,
                      table_rows[i].yields, table_rows[i].res);
        end

        // register extremes, frames cut short where they would be long
        write_regs(13'd1024, 13'd1, 13'd4, 13'd0);
        for (int i = 0; i < 40; i++) send_item(OP_PIXEL, $urandom);
        write_regs(13'd2047, 13'd8191, 13'd7, 13'd3);
        for (int i = 0; i < 30; i++) send_item(OP_PIXEL, $urandom);
        write_regs(13'd1, 13'd4096, 13'd0, 13'd2);
        for (int i = 0; i < 30; i++) send_item(OP_PIXEL, $urandom);
        // width 0 acts as 1: narrow rows under the widest window
        write_regs(13'd0, 13'd9, 13'd4, 13'd3);
        random_frame(9, 6, 0);

        // random frames, mostly small
        start = items_sent;
        while (items_sent - start < RAND_ITEMS) begin
            wv = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            hv = $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0) wv = 0;
            if ($urandom_range(0, 19) == 0) hv = 0;
            cv = $urandom_range(0, 7);
            r  = $urandom_range(0, 3);
            write_regs(wv, hv, cv, 13'(r));
            calm = ($urandom_range(0, 4) == 0);
            w = (wv == 0) ? 1 : wv;
            h = (hv == 0) ? 1 : hv;
            random_frame(w * h, r * w + r, $urandom_range(0, 9) == 0);
        end

        drain_all();
        if (pending_pix.size() != 0) errors++;
        $display("%0d items over %0d register settings, %0d output pixels checked",
                 items_sent, phases, pixels_seen);
        $display("%0d frames ended; widths 1..16 and 1024, radius 0..3, 1..4 lanes, %s",
                 frames_done, "early flushes and surplus pixels");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
